// ===== rtl/crq_pkg.sv =====
// ----------------------------------------------------------------------------
// Coalescing response queue package
// Shared constants, operation codes, sequencer states and cell control word.
// ----------------------------------------------------------------------------
package crq_pkg;

   localparam int DEPTH_DEFAULT       = 16;
   localparam int TYPE_BITS_DEFAULT   = 3;
   localparam int HANDLE_BITS_DEFAULT = 32;

   localparam int COUNT_BITS = 5;
   localparam int MASK_BITS  = 8;
   localparam logic [MASK_BITS-1:0] MASK_RESET = 8'h03;

   localparam logic FUNC_ENQUEUE = 1'b0;
   localparam logic FUNC_DEQUEUE = 1'b1;

   typedef enum logic {
      ST_IDLE,
      ST_WORK
   } state_type;

   typedef struct packed {
      logic mark;
      logic squeeze;
      logic pop;
      logic push;
   } cell_ctl_type;

endpackage

// ===== rtl/crq_cell.sv =====
// ----------------------------------------------------------------------------
// Coalescing response queue cell
// One queue slot: holds a type, a handle and a removal mark, and loads from
// the slot above on a pop or while a marked slot lies at or below it.
// ----------------------------------------------------------------------------
module crq_cell #(
   parameter int TYPE_BITS   = crq_pkg::TYPE_BITS_DEFAULT,
   parameter int HANDLE_BITS = crq_pkg::HANDLE_BITS_DEFAULT,
   parameter int OCC_W       = 5,
   parameter int INDEX       = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  crq_pkg::cell_ctl_type  ctl,
   input  logic [OCC_W-1:0]       occ_count,
   input  logic [TYPE_BITS-1:0]   key_type,
   input  logic [TYPE_BITS-1:0]   push_type,
   input  logic [HANDLE_BITS-1:0] push_handle,
   input  logic [TYPE_BITS-1:0]   up_type,
   input  logic [HANDLE_BITS-1:0] up_handle,
   input  logic                   up_dead,
   input  logic                   dead_below,
   output logic                   dead_here,
   output logic [TYPE_BITS-1:0]   cell_type,
   output logic [HANDLE_BITS-1:0] cell_handle,
   output logic                   cell_dead
);

   localparam logic [OCC_W-1:0] MY_INDEX = OCC_W'(INDEX);

   logic [TYPE_BITS-1:0]   type_ff, type_in;
   logic [HANDLE_BITS-1:0] handle_ff, handle_in;
   logic                   dead_ff, dead_in;

   assign dead_here = dead_below | dead_ff;

   always_comb begin
      type_in   = type_ff;
      handle_in = handle_ff;
      dead_in   = dead_ff;
      if (ctl.mark) begin
         dead_in = (MY_INDEX < occ_count) && (type_ff == key_type);
      end else if (ctl.pop || (ctl.squeeze && dead_here)) begin
         type_in   = up_type;
         handle_in = up_handle;
         dead_in   = up_dead;
      end else if (ctl.push && (occ_count == MY_INDEX)) begin
         type_in   = push_type;
         handle_in = push_handle;
      end
   end

   always_ff @(posedge clock) begin
      type_ff   <= type_in;
      handle_ff <= handle_in;
      if (reset) begin
         dead_ff <= 1'b0;
      end else begin
         dead_ff <= dead_in;
      end
   end

   assign cell_type   = type_ff;
   assign cell_handle = handle_ff;
   assign cell_dead   = dead_ff;

endmodule

// ===== rtl/coalescing_response_queue_core.sv =====
// ----------------------------------------------------------------------------
// Coalescing response queue core
// Bounded queue of typed entries in a row of slot cells; an enqueue of a
// coalescing type first squeezes out queued entries of the same type.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_tvalid/tready    | tuser func, tdata type+handle
//   rsp     | out       | rsp_tvalid/tready    | tdata result word
//   csr     | in        | csr_wr_en            | csr_wr_data coalesce mask
//
// A word is accepted, then finished into the output register.
// A coalescing enqueue finishes only once the cell row has dropped every
// queued entry it marked; the row drops one marked slot per cycle.
// Reset empties the queue and sets the mask to types 0 and 1.
// A stalled result holds in the output register; the next word is taken
// meanwhile and finishes once the register frees.
// ----------------------------------------------------------------------------
module coalescing_response_queue_core #(
   parameter int DEPTH       = crq_pkg::DEPTH_DEFAULT,
   parameter int TYPE_BITS   = crq_pkg::TYPE_BITS_DEFAULT,
   parameter int HANDLE_BITS = crq_pkg::HANDLE_BITS_DEFAULT,
   localparam int REQ_RAW    = TYPE_BITS + HANDLE_BITS,
   localparam int REQ_W      = ((REQ_RAW + 7) / 8) * 8,
   localparam int RSP_RAW    = 1 + TYPE_BITS + HANDLE_BITS + 2 * crq_pkg::COUNT_BITS + 1,
   localparam int RSP_W      = ((RSP_RAW + 7) / 8) * 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [REQ_W-1:0]              req_tdata,  // entry_type, entry_handle
   input  logic                          req_tuser,  // func
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [RSP_W-1:0]              rsp_tdata,  // out_valid, out_type, out_handle,
                                                     // removed_count, overflow, fill_level
   input  logic                          csr_wr_en,
   input  logic [crq_pkg::MASK_BITS-1:0] csr_wr_data
);

   localparam int OCC_W = $clog2(DEPTH + 1);
   localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(DEPTH);

   crq_pkg::state_type    state_ff, state_in;
   crq_pkg::cell_ctl_type ctl;

   logic [crq_pkg::MASK_BITS-1:0] mask_ff;
   logic                          func_ff;
   logic [TYPE_BITS-1:0]          type_ff;
   logic [HANDLE_BITS-1:0]        handle_ff;
   logic [OCC_W-1:0]              occ_ff, occ_in;
   logic [OCC_W-1:0]              removed_ff, removed_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]              rsp_data_ff, rsp_data_in;

   logic                   accept, finish, any_dead, out_free, coalesces, overflow;
   logic [TYPE_BITS-1:0]   req_type;
   logic [HANDLE_BITS-1:0] req_handle;
   logic [7:0]             type_wide;
   logic [TYPE_BITS-1:0]   out_type;
   logic [HANDLE_BITS-1:0] out_handle;

   logic [TYPE_BITS-1:0]   cell_type_w   [DEPTH];
   logic [HANDLE_BITS-1:0] cell_handle_w [DEPTH];
   logic                   cell_dead_w   [DEPTH];
   logic [TYPE_BITS-1:0]   up_type_w     [DEPTH];
   logic [HANDLE_BITS-1:0] up_handle_w   [DEPTH];
   logic                   up_dead_w     [DEPTH];
   logic                   chain_w       [DEPTH+1];

   assign req_type   = req_tdata[TYPE_BITS-1:0];
   assign req_handle = req_tdata[TYPE_BITS +: HANDLE_BITS];
   assign accept     = req_tvalid & req_tready;
   assign type_wide  = 8'(req_type);
   assign coalesces  = (type_wide < 8'd8) && mask_ff[type_wide[2:0]];
   assign any_dead   = chain_w[DEPTH];
   assign out_free   = ~rsp_valid_ff | rsp_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         crq_pkg::ST_IDLE: if (accept) state_in = crq_pkg::ST_WORK;
         crq_pkg::ST_WORK: if (finish) state_in = crq_pkg::ST_IDLE;
         default:          state_in = crq_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_tready  = 1'b0;
      finish      = 1'b0;
      ctl.mark    = 1'b0;
      ctl.squeeze = 1'b0;
      ctl.pop     = 1'b0;
      ctl.push    = 1'b0;
      case (state_ff)
         crq_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            ctl.mark   = req_tvalid && (req_tuser == crq_pkg::FUNC_ENQUEUE) && coalesces;
         end
         crq_pkg::ST_WORK: begin
            ctl.squeeze = any_dead;
            finish      = ~any_dead & out_free;
            ctl.push    = finish && (func_ff == crq_pkg::FUNC_ENQUEUE) && (occ_ff != OCC_FULL);
            ctl.pop     = finish && (func_ff == crq_pkg::FUNC_DEQUEUE) && (occ_ff != '0);
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   assign chain_w[0] = 1'b0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      if (i == DEPTH - 1) begin : g_top
         assign up_type_w[i]   = '0;
         assign up_handle_w[i] = '0;
         assign up_dead_w[i]   = 1'b0;
      end else begin : g_mid
         assign up_type_w[i]   = cell_type_w[i+1];
         assign up_handle_w[i] = cell_handle_w[i+1];
         assign up_dead_w[i]   = cell_dead_w[i+1];
      end

      crq_cell #(
         .TYPE_BITS   (TYPE_BITS),
         .HANDLE_BITS (HANDLE_BITS),
         .OCC_W       (OCC_W),
         .INDEX       (i)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .occ_count   (occ_ff),
         .key_type    (req_type),
         .push_type   (type_ff),
         .push_handle (handle_ff),
         .up_type     (up_type_w[i]),
         .up_handle   (up_handle_w[i]),
         .up_dead     (up_dead_w[i]),
         .dead_below  (chain_w[i]),
         .dead_here   (chain_w[i+1]),
         .cell_type   (cell_type_w[i]),
         .cell_handle (cell_handle_w[i]),
         .cell_dead   (cell_dead_w[i])
      );
   end

   always_comb begin
      occ_in     = occ_ff;
      removed_in = removed_ff;
      if (accept) begin
         removed_in = '0;
      end else if (ctl.squeeze) begin
         occ_in     = occ_ff - OCC_W'(1);
         removed_in = removed_ff + OCC_W'(1);
      end else if (ctl.push) begin
         occ_in = occ_ff + OCC_W'(1);
      end else if (ctl.pop) begin
         occ_in = occ_ff - OCC_W'(1);
      end
   end

   assign overflow   = (func_ff == crq_pkg::FUNC_ENQUEUE) && (occ_ff == OCC_FULL);
   assign out_type   = ctl.pop ? cell_type_w[0] : '0;
   assign out_handle = ctl.pop ? cell_handle_w[0] : '0;

   always_comb begin
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = RSP_W'({crq_pkg::COUNT_BITS'(occ_in), overflow,
                                crq_pkg::COUNT_BITS'(removed_ff), out_handle, out_type,
                                ctl.pop});
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (accept) begin
         func_ff   <= req_tuser;
         type_ff   <= req_type;
         handle_ff <= req_handle;
      end
      if (reset) begin
         state_ff     <= crq_pkg::ST_IDLE;
         mask_ff      <= crq_pkg::MASK_RESET;
         occ_ff       <= '0;
         removed_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         removed_ff   <= removed_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            mask_ff <= csr_wr_data;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== rtl/crq_checker.sv =====
// ----------------------------------------------------------------------------
// Coalescing response queue checker
// Port-level properties of the queue core, bound to every instance.
// ----------------------------------------------------------------------------
module crq_checker #(
   parameter int DEPTH       = crq_pkg::DEPTH_DEFAULT,
   parameter int TYPE_BITS   = crq_pkg::TYPE_BITS_DEFAULT,
   parameter int HANDLE_BITS = crq_pkg::HANDLE_BITS_DEFAULT,
   parameter int RSP_W       = 48
) (
   input logic             clock,
   input logic             reset,
   input logic             req_tvalid,
   input logic             req_tready,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata
);

   localparam int REM_LSB  = 1 + TYPE_BITS + HANDLE_BITS;
   localparam int OVF_BIT  = REM_LSB + crq_pkg::COUNT_BITS;
   localparam int FILL_LSB = OVF_BIT + 1;

   logic                           out_valid, overflow;
   logic [crq_pkg::COUNT_BITS-1:0] removed_count, fill_level;

   assign out_valid     = rsp_tdata[0];
   assign overflow      = rsp_tdata[OVF_BIT];
   assign removed_count = rsp_tdata[REM_LSB +: crq_pkg::COUNT_BITS];
   assign fill_level    = rsp_tdata[FILL_LSB +: crq_pkg::COUNT_BITS];

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result word changed");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("word taken while previous word still in work");

   a_dequeue_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && out_valid |-> !overflow && removed_count == '0)
      else $error("dequeue result carries enqueue status");

   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && overflow |->
         fill_level == crq_pkg::COUNT_BITS'(DEPTH))
      else $error("overflow without a full queue");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (DEPTH >= 32) || (int'(fill_level) <= DEPTH))
      else $error("fill level beyond depth");

endmodule

bind coalescing_response_queue_core crq_checker #(
   .DEPTH       (DEPTH),
   .TYPE_BITS   (TYPE_BITS),
   .HANDLE_BITS (HANDLE_BITS),
   .RSP_W       (RSP_W)
) u_crq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
